// ===== hw/rtl/iyfr_pkg.sv =====
// Shared types and constants for the yaw-gyro frame receiver.
// Used by the front framer, the op queue, the back executor and the top level.
package iyfr_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int IDX_W       = 4;
  localparam int OUT_W       = 144;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_TYPE   = 4'd1;
  localparam logic [IDX_W-1:0] IDX_RAW_LO = 4'd6;
  localparam logic [IDX_W-1:0] IDX_RAW_HI = 4'd7;
  localparam logic [IDX_W-1:0] IDX_VER_LO = 4'd8;
  localparam logic [IDX_W-1:0] IDX_VER_HI = 4'd9;

  localparam logic [1:0] FUNC_BYTE      = 2'd0;
  localparam logic [1:0] FUNC_TICK      = 2'd1;
  localparam logic [1:0] FUNC_READ_FLAG = 2'd2;
  localparam logic [1:0] FUNC_CLR_TURNS = 2'd3;

  localparam logic [1:0] DONE_NONE = 2'd0;
  localparam logic [1:0] DONE_OK   = 2'd1;
  localparam logic [1:0] DONE_BAD  = 2'd2;

  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_READ_FLAG = 3'd2;
  localparam logic [2:0] OP_CLR_TURNS = 3'd3;
  localparam logic [2:0] OP_RATE      = 3'd4;
  localparam logic [2:0] OP_ANGLE     = 3'd5;
  localparam logic [2:0] OP_OTHER     = 3'd6;
  localparam logic [2:0] OP_BAD       = 3'd7;

  localparam logic signed [24:0] ANGLE_SCALE = 25'sd360;
  localparam logic signed [27:0] RATE_SCALE  = 28'sd4000;
  localparam logic signed [16:0] TURN_DEG    = 17'sd360;
  localparam logic signed [25:0] HALF_TURN   = 26'sd11796480;

  localparam logic [2:0] REG_OFFLINE_TIMEOUT = 3'd0;
  localparam logic [15:0] TIMEOUT_RESET      = 16'd500;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [27:0] val;
    logic [15:0]        ver;
  } iyfr_op_t;

endpackage

// ===== hw/rtl/imu_yaw_frame_receiver_core.sv =====
// Yaw-gyro UART frame receiver: top level with the configuration port.
// Depends on iyfr_pkg, iyfr_front, iyfr_queue and iyfr_back.
//
// Usage:
//   Input stream: one item per transfer. in_tuser selects the item (received
//   byte, one-millisecond tick, read-and-clear of update flags, clear of the
//   turn count); in_tdata carries the byte. Every item yields one result.
//   Result stream: out_tdata carries the yaw, rate, saturated accumulated
//   angle, turn count, version word, online and update flags, and frame status.
//   Config port: one register, offline_timeout, at byte address 0; write it
//   only while no item is in flight.
//   Throughput: one item per cycle while the queue is not full. An accepted
//   item is written into the queue, then popped into the result register.
//   Reset: framer hunts for a header, the sensor state and queue clear, timeout returns to 500.
//   Stall: when out_tready is low the result register holds, the two-entry
//   queue fills, and in_tready drops until the back part drains.
module imu_yaw_frame_receiver_core import iyfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic [1:0]       in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // [24:0] angle_z, [52:25] rate_z,
                                       // [84:53] accumulated_angle, [116:85] turn_count,
                                       // [132:117] firmware_version, [133] online,
                                       // [134] rate_updated, [135] angle_updated,
                                       // [137:136] frame_done, [143:138] zero
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0] timeout_r;
  logic        accept;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  iyfr_op_t    front_op;
  iyfr_op_t    head_op;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_OFFLINE_TIMEOUT) ? {16'h0000, timeout_r} : 32'h0;
  assign in_tready  = !q_full;
  assign accept     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == REG_OFFLINE_TIMEOUT)) begin
      timeout_r <= cfg_pwdata[15:0];
    end
  end

  iyfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .func    (in_tuser),
    .rx_byte (in_tdata),
    .op      (front_op)
  );

  iyfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  iyfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_valid),
    .head_op         (head_op),
    .pop             (q_pop),
    .offline_timeout (timeout_r),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

endmodule

// ===== hw/rtl/iyfr_front.sv =====
// Front part: hunts for the header, collects a frame, checks the sum and classifies each item.
// Depends on iyfr_pkg.
module iyfr_front import iyfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] func,
  input  logic [7:0] rx_byte,
  output iyfr_op_t   op
);

  logic             hunting_r, hunting_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       type_r, raw_lo_r, raw_hi_r, ver_lo_r, ver_hi_r;
  logic signed [15:0] raw_s;
  logic signed [24:0] yaw_w;
  logic signed [27:0] rate_w;
  logic             store;

  assign raw_s  = signed'({raw_hi_r, raw_lo_r});
  assign yaw_w  = 25'(raw_s) * ANGLE_SCALE;
  assign rate_w = 28'(raw_s) * RATE_SCALE;
  assign store  = accept && (func == FUNC_BYTE) && !hunting_r && (idx_r < LAST_IDX);

  always_comb begin
    hunting_nxt = hunting_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    op.kind     = OP_NONE;
    op.val      = 28'sd0;
    op.ver      = {ver_hi_r, ver_lo_r};
    unique case (func)
      FUNC_TICK:      op.kind = OP_TICK;
      FUNC_READ_FLAG: op.kind = OP_READ_FLAG;
      FUNC_CLR_TURNS: op.kind = OP_CLR_TURNS;
      default: begin
        if (hunting_r) begin
          if (rx_byte == HDR_BYTE) begin
            hunting_nxt = 1'b0;
            idx_nxt     = 4'd1;
            sum_nxt     = rx_byte;
          end
        end else if (idx_r < LAST_IDX) begin
          idx_nxt = idx_r + 4'd1;
          sum_nxt = sum_r + rx_byte;
        end else begin
          hunting_nxt = 1'b1;
          idx_nxt     = '0;
          sum_nxt     = '0;
          if (sum_r != rx_byte) begin
            op.kind = OP_BAD;
          end else if (type_r == TYPE_RATE) begin
            op.kind = OP_RATE;
            op.val  = rate_w;
          end else if (type_r == TYPE_ANGLE) begin
            op.kind = OP_ANGLE;
            op.val  = 28'(yaw_w);
          end else begin
            op.kind = OP_OTHER;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r <= 1'b1;
      idx_r     <= '0;
      sum_r     <= '0;
    end else if (accept) begin
      hunting_r <= hunting_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      case (idx_r)
        IDX_TYPE:   type_r   <= rx_byte;
        IDX_RAW_LO: raw_lo_r <= rx_byte;
        IDX_RAW_HI: raw_hi_r <= rx_byte;
        IDX_VER_LO: ver_lo_r <= rx_byte;
        IDX_VER_HI: ver_hi_r <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/iyfr_queue.sv =====
// Two-entry queue of classified ops between the front and back parts.
// Depends on iyfr_pkg.
module iyfr_queue import iyfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  iyfr_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output iyfr_op_t head_op
);

  iyfr_op_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_op    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/iyfr_back.sv =====
// Back part: applies classified ops to the sensor state and holds the result register.
// Depends on iyfr_pkg.
module iyfr_back import iyfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  iyfr_op_t         head_op,
  output logic             pop,
  input  logic [15:0]      offline_timeout,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic signed [24:0] yaw_r, yaw_nxt;
  logic signed [27:0] rate_r, rate_nxt;
  logic [31:0]        turns_r, turns_nxt;
  logic [15:0]        ver_r, ver_nxt;
  logic [1:0]         upd_r, upd_seen, upd_nxt;
  logic               online_r, online_nxt;
  logic [15:0]        ticks_r, ticks_nxt, ticks_inc;
  logic [1:0]         done;
  logic signed [25:0] diff;
  logic               turns_small;
  logic signed [16:0] turn_prod;
  logic signed [32:0] turn_shift;
  logic signed [33:0] acc_w;
  logic [31:0]        acc;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  assign pop        = head_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign ticks_inc  = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;
  assign diff       = 26'(signed'(head_op.val[24:0])) - 26'(yaw_r);

  always_comb begin
    yaw_nxt    = yaw_r;
    rate_nxt   = rate_r;
    turns_nxt  = turns_r;
    ver_nxt    = ver_r;
    upd_seen   = upd_r;
    online_nxt = online_r;
    ticks_nxt  = ticks_r;
    done       = DONE_NONE;
    unique case (head_op.kind)
      OP_TICK: begin
        ticks_nxt = ticks_inc;
        if (online_r && (ticks_inc >= offline_timeout)) online_nxt = 1'b0;
      end
      OP_CLR_TURNS: turns_nxt = '0;
      OP_RATE: begin
        rate_nxt    = head_op.val;
        upd_seen[0] = 1'b1;
        online_nxt  = 1'b1;
        ticks_nxt   = '0;
        done        = DONE_OK;
      end
      OP_ANGLE: begin
        yaw_nxt     = signed'(head_op.val[24:0]);
        ver_nxt     = head_op.ver;
        upd_seen[1] = 1'b1;
        online_nxt  = 1'b1;
        ticks_nxt   = '0;
        done        = DONE_OK;
        if (diff > HALF_TURN) begin
          turns_nxt = turns_r - 32'd1;
        end else if (diff < -HALF_TURN) begin
          turns_nxt = turns_r + 32'd1;
        end
      end
      OP_OTHER: done = DONE_OK;
      OP_BAD:   done = DONE_BAD;
      default: ;
    endcase
    upd_nxt = (head_op.kind == OP_READ_FLAG) ? 2'b00 : upd_seen;
  end

  // Saturate yaw plus turns times a full turn; only small turn counts can stay in range.
  assign turns_small = (turns_nxt[31:7] == {25{turns_nxt[31]}});
  assign turn_prod   = 17'(signed'(turns_nxt[7:0])) * TURN_DEG;
  assign turn_shift  = {turn_prod, 16'h0000};
  assign acc_w       = 34'(turn_shift) + 34'(yaw_nxt);

  always_comb begin
    if (!turns_small) begin
      acc = turns_nxt[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (acc_w[33:31] != {3{acc_w[33]}}) begin
      acc = acc_w[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      acc = acc_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r       <= '0;
      rate_r      <= '0;
      turns_r     <= '0;
      ver_r       <= '0;
      upd_r       <= '0;
      online_r    <= 1'b0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        yaw_r    <= yaw_nxt;
        rate_r   <= rate_nxt;
        turns_r  <= turns_nxt;
        ver_r    <= ver_nxt;
        upd_r    <= upd_nxt;
        online_r <= online_nxt;
        ticks_r  <= ticks_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= {6'b0, done, upd_seen[1], upd_seen[0], online_nxt, ver_nxt,
                     turns_nxt, acc, rate_nxt, yaw_nxt};
    end
  end

  a_online_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(online_r) |-> $past(pop && (head_op.kind == OP_RATE || head_op.kind == OP_ANGLE)))
    else $error("online set without a good rate or angle frame");

  a_turns_change: assert property (@(posedge clk) disable iff (!rst_n)
    (turns_r != $past(turns_r)) |->
      $past(pop && (head_op.kind == OP_ANGLE || head_op.kind == OP_CLR_TURNS)))
    else $error("turn count changed without an angle frame or clear");

  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_op.kind == OP_READ_FLAG) |=> (upd_r == 2'b00))
    else $error("update flags not cleared after read");

  a_ticks_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head_op.kind == OP_RATE || head_op.kind == OP_ANGLE)) |=> (ticks_r == 16'd0))
    else $error("tick count not restarted by a good frame");

endmodule

// ===== verif/imu_yaw_frame_receiver_core_tb.sv =====
// Self-checking testbench for imu_yaw_frame_receiver_core: frame, tick and flag items
// in, one status report out per item, compared against an in-bench predictor.
// Depends on iyfr_pkg and the imu_yaw_frame_receiver_core RTL.
`timescale 1ns / 1ps

module testbench;
  import iyfr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam longint FULL_TURN_Q = 64'sd23592960;
  localparam longint HALF_TURN_Q = 64'sd11796480;
  localparam logic [15:0] RAW_170 = 16'd30947;

  typedef struct {
    logic [1:0] func;
    logic [7:0] data;
  } gyro_item_t;

  typedef struct {
    logic signed [24:0] angle_z;
    logic signed [27:0] rate_z;
    logic signed [31:0] accumulated_angle;
    logic [31:0]        turn_count;
    logic [15:0]        firmware_version;
    logic               online;
    logic               rate_updated;
    logic               angle_updated;
    logic [1:0]         frame_done;
    logic [5:0]         pad;
  } yaw_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  imu_yaw_frame_receiver_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  gyro_item_t  rx_items[$];
  yaw_report_t reports_due[$];
  int fail_cnt = 0;
  logic in_fire = 1'b0;
  logic hold_results_req = 1'b0;

  // predictor state
  logic        p_hunting = 1'b1;
  logic [3:0]  p_idx = '0;
  logic [7:0]  p_store [0:15];
  logic [7:0]  p_sum = '0;
  int          p_yaw = 0;
  int          p_last = 0;
  int          p_rate = 0;
  logic [31:0] p_turns = '0;
  logic [15:0] p_ver = '0;
  logic [1:0]  p_flags = '0;
  logic        p_online = 1'b0;
  logic [15:0] p_ticks = '0;
  logic [15:0] p_timeout = TIMEOUT_RESET;

  task automatic track_gyro_item(input logic [1:0] func, input logic [7:0] b);
    logic [1:0] done;
    logic [1:0] seen;
    logic signed [15:0] raw;
    longint acc;
    longint diff;
    yaw_report_t r;
    done = DONE_NONE;
    case (func)
      FUNC_BYTE: begin
        if (p_hunting) begin
          if (b == HDR_BYTE) begin
            p_store[0] = b;
            p_sum = b;
            p_idx = 4'd1;
            p_hunting = 1'b0;
          end
        end else if (p_idx < LAST_IDX) begin
          p_store[p_idx] = b;
          p_sum = p_sum + b;
          p_idx = p_idx + 4'd1;
        end else begin
          p_hunting = 1'b1;
          p_idx = '0;
          if (p_sum != b) begin
            done = DONE_BAD;
          end else begin
            done = DONE_OK;
            raw = {p_store[IDX_RAW_HI], p_store[IDX_RAW_LO]};
            if (p_store[IDX_TYPE] == TYPE_RATE) begin
              p_rate = int'(raw) * 4000;
              p_flags[0] = 1'b1;
              p_online = 1'b1;
              p_ticks = '0;
            end else if (p_store[IDX_TYPE] == TYPE_ANGLE) begin
              p_yaw = int'(raw) * 360;
              p_ver = {p_store[IDX_VER_HI], p_store[IDX_VER_LO]};
              diff = longint'(p_yaw) - longint'(p_last);
              if (diff > HALF_TURN_Q) p_turns = p_turns - 32'd1;
              else if (diff < -HALF_TURN_Q) p_turns = p_turns + 32'd1;
              p_last = p_yaw;
              p_flags[1] = 1'b1;
              p_online = 1'b1;
              p_ticks = '0;
            end
          end
          p_sum = '0;
        end
      end
      FUNC_TICK: begin
        if (p_ticks != 16'hFFFF) p_ticks = p_ticks + 16'd1;
        if (p_online && p_ticks >= p_timeout) p_online = 1'b0;
      end
      FUNC_CLR_TURNS: p_turns = '0;
      default: ;
    endcase
    seen = p_flags;
    if (func == FUNC_READ_FLAG) p_flags = '0;
    acc = longint'(p_yaw) + longint'($signed(p_turns)) * FULL_TURN_Q;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    r.angle_z = p_yaw[24:0];
    r.rate_z = p_rate[27:0];
    r.accumulated_angle = acc[31:0];
    r.turn_count = p_turns;
    r.firmware_version = p_ver;
    r.online = p_online;
    r.rate_updated = seen[0];
    r.angle_updated = seen[1];
    r.frame_done = done;
    r.pad = '0;
    reports_due.push_back(r);
  endtask

  // input side: acceptance and prediction, result side: checking
  always @(posedge clk) begin
    yaw_report_t got;
    yaw_report_t want;
    if (rst_n) begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) track_gyro_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got.angle_z = out_tdata[24:0];
        got.rate_z = out_tdata[52:25];
        got.accumulated_angle = out_tdata[84:53];
        got.turn_count = out_tdata[116:85];
        got.firmware_version = out_tdata[132:117];
        got.online = out_tdata[133];
        got.rate_updated = out_tdata[134];
        got.angle_updated = out_tdata[135];
        got.frame_done = out_tdata[137:136];
        got.pad = out_tdata[143:138];
        if (reports_due.size() == 0) begin
          fail_cnt++;
          $error("unexpected result transfer, tdata %h", out_tdata);
        end else begin
          want = reports_due.pop_front();
          if (got.angle_z !== want.angle_z) begin
            fail_cnt++;
            $error("angle_z expected %0d actual %0d", want.angle_z, got.angle_z);
          end
          if (got.rate_z !== want.rate_z) begin
            fail_cnt++;
            $error("rate_z expected %0d actual %0d", want.rate_z, got.rate_z);
          end
          if (got.accumulated_angle !== want.accumulated_angle) begin
            fail_cnt++;
            $error("accumulated_angle expected %0d actual %0d",
                   want.accumulated_angle, got.accumulated_angle);
          end
          if (got.turn_count !== want.turn_count) begin
            fail_cnt++;
            $error("turn_count expected %0d actual %0d",
                   $signed(want.turn_count), $signed(got.turn_count));
          end
          if (got.firmware_version !== want.firmware_version) begin
            fail_cnt++;
            $error("firmware_version expected %h actual %h",
                   want.firmware_version, got.firmware_version);
          end
          if (got.online !== want.online) begin
            fail_cnt++;
            $error("online expected %b actual %b", want.online, got.online);
          end
          if (got.rate_updated !== want.rate_updated) begin
            fail_cnt++;
            $error("rate_updated expected %b actual %b", want.rate_updated, got.rate_updated);
          end
          if (got.angle_updated !== want.angle_updated) begin
            fail_cnt++;
            $error("angle_updated expected %b actual %b", want.angle_updated, got.angle_updated);
          end
          if (got.frame_done !== want.frame_done) begin
            fail_cnt++;
            $error("frame_done expected %0d actual %0d", want.frame_done, got.frame_done);
          end
          if (got.pad !== want.pad) begin
            fail_cnt++;
            $error("pad bits expected %h actual %h", want.pad, got.pad);
          end
        end
      end
    end
  end

  // driver: bursts with random gaps, hold each item until its transfer
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    logic nv;
    logic [7:0] nd;
    logic [1:0] nu;
    nv = 1'b0;
    nd = in_tdata;
    nu = in_tuser;
    if (rst_n) begin
      if (in_tvalid && in_fire) void'(rx_items.pop_front());
      if (in_tvalid && !in_fire) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (rx_items.size() > 0) begin
        nv = 1'b1;
        nd = rx_items[0].data;
        nu = rx_items[0].func;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
    in_tuser <= nu;
  end

  // receiver: random stall segments, full-ready stretches, one long hold-off on request
  int ready_left = 0;
  int ready_pct = 100;
  int long_hold_left = 0;
  logic long_hold_used = 1'b0;
  always @(negedge clk) begin
    logic nr;
    nr = 1'b0;
    if (rst_n) begin
      if (hold_results_req && !long_hold_used) begin
        long_hold_used = 1'b1;
        long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
      end else begin
        if (ready_left == 0) begin
          ready_left = $urandom_range(1, 60);
          ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
        end
        ready_left--;
        nr = ($urandom_range(1, 100) <= ready_pct);
      end
    end
    out_tready <= nr;
  end

  // watchdog: no transfer on either side while work is outstanding
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((rx_items.size() != 0 || reports_due.size() != 0) &&
        !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** imu_yaw_frame_receiver_core: FAILED **");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic queue_item(input logic [1:0] func, input logic [7:0] b);
    gyro_item_t it;
    it.func = func;
    it.data = b;
    rx_items.push_back(it);
  endtask

  task automatic queue_frame(input logic [7:0] kind, input logic [15:0] raw,
                             input logic [15:0] ver, input logic [7:0] skew);
    logic [7:0] bytes [0:9];
    logic [7:0] sum;
    sum = '0;
    bytes[0] = HDR_BYTE;
    bytes[1] = kind;
    for (int i = 2; i < 6; i++) bytes[i] = 8'($urandom);
    bytes[6] = raw[7:0];
    bytes[7] = raw[15:8];
    bytes[8] = ver[7:0];
    bytes[9] = ver[15:8];
    for (int i = 0; i < 10; i++) begin
      sum = sum + bytes[i];
      queue_item(FUNC_BYTE, bytes[i]);
    end
    queue_item(FUNC_BYTE, sum + skew);
  endtask

  task automatic wait_reports_drained();
    while (rx_items.size() != 0 || reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(REG_OFFLINE_TIMEOUT << 2);
    cfg_pwdata <= {16'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    p_timeout = value;
  endtask

  task automatic queue_random_traffic(input int count);
    int n;
    int sel;
    int k;
    logic [7:0] kind;
    logic [7:0] skew;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        k = $urandom_range(0, 19);
        kind = (k < 9) ? TYPE_RATE : (k < 18) ? TYPE_ANGLE : 8'($urandom);
        skew = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        queue_frame(kind, 16'($urandom), 16'($urandom), skew);
        n += 11;
      end else if (sel < 65) begin
        k = $urandom_range(0, 9);
        queue_item(FUNC_BYTE, HDR_BYTE);
        for (int i = 0; i < k; i++) queue_item(FUNC_BYTE, 8'($urandom));
        n += k + 1;
      end else if (sel < 85) begin
        queue_item(FUNC_TICK, 8'($urandom));
        n++;
      end else if (sel < 91) begin
        queue_item(FUNC_READ_FLAG, 8'($urandom));
        n++;
      end else if (sel < 94) begin
        queue_item(FUNC_CLR_TURNS, 8'($urandom));
        n++;
      end else begin
        queue_item(FUNC_BYTE, 8'($urandom));
        n++;
      end
    end
  endtask

  task automatic queue_spin(input int laps, input logic up);
    for (int i = 0; i < laps; i++) begin
      queue_frame(TYPE_ANGLE, 16'd0, 16'($urandom), 8'd0);
      queue_frame(TYPE_ANGLE, up ? RAW_170 : -RAW_170, 16'($urandom), 8'd0);
      queue_frame(TYPE_ANGLE, up ? -RAW_170 : RAW_170, 16'($urandom), 8'd0);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset state, ignored bytes, extremes, unknown type, bad sum, flags
    queue_item(FUNC_TICK, 8'h00);
    queue_item(FUNC_BYTE, 8'h00);
    queue_item(FUNC_BYTE, 8'hFF);
    queue_item(FUNC_READ_FLAG, 8'hFF);
    queue_frame(TYPE_RATE, 16'h8000, 16'h0000, 8'd0);
    queue_frame(TYPE_ANGLE, 16'h7FFF, 16'hFFFF, 8'd0);
    queue_frame(TYPE_ANGLE, 16'h8000, 16'h0000, 8'd0);
    queue_frame(8'h00, 16'h1234, 16'h5678, 8'd0);
    queue_frame(TYPE_RATE, 16'h7FFF, 16'hFFFF, 8'd1);
    queue_item(FUNC_READ_FLAG, 8'h00);
    queue_item(FUNC_READ_FLAG, 8'h00);
    queue_item(FUNC_CLR_TURNS, 8'h00);
    queue_item(FUNC_TICK, 8'hFF);
    wait_reports_drained();

    // timeout of one: online drops on the first tick
    write_timeout(16'd1);
    queue_frame(TYPE_RATE, 16'h0001, 16'h0000, 8'd0);
    queue_item(FUNC_TICK, 8'h00);
    queue_item(FUNC_TICK, 8'h00);
    wait_reports_drained();

    write_timeout(16'($urandom_range(2, 20)));
    hold_results_req = 1'b1;
    queue_random_traffic(650);
    wait_reports_drained();

    write_timeout(16'($urandom_range(10, 300)));
    queue_random_traffic(600);
    wait_reports_drained();

    // spin both ways to build up the turn count
    queue_item(FUNC_CLR_TURNS, 8'h00);
    queue_spin(8, 1'b1);
    queue_item(FUNC_CLR_TURNS, 8'h00);
    queue_spin(8, 1'b0);
    wait_reports_drained();

    // longer timeout: online holds until the tick count reaches it
    write_timeout(16'd40);
    queue_frame(TYPE_ANGLE, 16'($urandom), 16'($urandom), 8'd0);
    for (int i = 0; i < 45; i++) queue_item(FUNC_TICK, 8'($urandom));
    queue_item(FUNC_READ_FLAG, 8'h00);
    wait_reports_drained();

    write_timeout(TIMEOUT_RESET);
    queue_random_traffic(60);
    wait_reports_drained();
    repeat (10) @(posedge clk);

    if (reports_due.size() != 0) begin
      fail_cnt++;
      $error("%0d results never arrived", reports_due.size());
    end
    if (fail_cnt == 0) begin
      $display("** imu_yaw_frame_receiver_core: PASSED **");
    end else begin
      $display("** imu_yaw_frame_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/iyfr_pkg.sv
hw/rtl/iyfr_front.sv
hw/rtl/iyfr_queue.sv
hw/rtl/iyfr_back.sv
hw/rtl/imu_yaw_frame_receiver_core.sv
verif/imu_yaw_frame_receiver_core_tb.sv
